/* hw/rtl/sdsch_pkg.sv */
package sdsch_pkg;

  localparam int TRACK_W = 8;
  localparam int MOVE_W  = 9;

  // configuration register indexes
  localparam logic CFG_START_TRACK = 1'b0;
  localparam logic CFG_LAST_TRACK  = 1'b1;

  localparam logic [TRACK_W-1:0] START_TRACK_RESET = 8'd0;
  localparam logic [TRACK_W-1:0] LAST_TRACK_RESET  = 8'd199;

  typedef struct packed {
    logic [TRACK_W-1:0] request_track;
    logic               last_request;
  } request_t;

  typedef struct packed {
    logic [TRACK_W-1:0] served_track;
    logic [MOVE_W-1:0]  total_movement;
    logic               overflow;
    logic               last_result;
  } result_t;

  typedef enum logic [1:0] {
    SORT_HOLD   = 2'd0,
    SORT_INSERT = 2'd1,
    SORT_POP    = 2'd2
  } sort_op_t;

  typedef enum logic [1:0] {
    STK_HOLD = 2'd0,
    STK_PUSH = 2'd1,
    STK_POP  = 2'd2
  } stack_op_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    sort_op_t           sort_op;
    stack_op_t          stack_op;
    logic [TRACK_W-1:0] key;
  } cell_cmd_t;

  // what one cell shows its neighbors
  typedef struct packed {
    logic               sort_valid;
    logic [TRACK_W-1:0] sort_val;
    logic               stack_valid;
    logic [TRACK_W-1:0] stack_val;
    logic               gt;
  } cell_link_t;

endpackage

/* hw/rtl/sdsch_cell.sv */
module sdsch_cell (
  input  logic                   clk,
  input  logic                   rst,
  input  sdsch_pkg::cell_cmd_t   cmd,
  input  sdsch_pkg::cell_link_t  left,
  input  sdsch_pkg::cell_link_t  right,
  output sdsch_pkg::cell_link_t  link
);
  import sdsch_pkg::*;

  logic               sort_valid;
  logic [TRACK_W-1:0] sort_val;
  logic               stack_valid;
  logic [TRACK_W-1:0] stack_val;
  logic               gt;

  // an empty cell counts as larger than any key
  assign gt = !sort_valid || (sort_val > cmd.key);

  assign link.sort_valid  = sort_valid;
  assign link.sort_val    = sort_val;
  assign link.stack_valid = stack_valid;
  assign link.stack_val   = stack_val;
  assign link.gt          = gt;

  always_ff @(posedge clk) begin
    if (rst) begin
      sort_valid  <= 1'b0;
      stack_valid <= 1'b0;
    end else begin
      case (cmd.sort_op)
        SORT_INSERT: begin
          if (gt) begin
            sort_valid <= left.gt ? left.sort_valid : 1'b1;
          end
        end
        SORT_POP: sort_valid <= right.sort_valid;
        default: ;
      endcase
      case (cmd.stack_op)
        STK_PUSH: stack_valid <= left.stack_valid;
        STK_POP:  stack_valid <= right.stack_valid;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.sort_op)
      SORT_INSERT: begin
        if (gt) begin
          sort_val <= left.gt ? left.sort_val : cmd.key;
        end
      end
      SORT_POP: sort_val <= right.sort_val;
      default: ;
    endcase
    case (cmd.stack_op)
      STK_PUSH: stack_val <= left.stack_val;
      STK_POP:  stack_val <= right.stack_val;
      default: ;
    endcase
  end

endmodule

/* hw/rtl/scan_disk_scheduler.sv */
// scan (elevator) disk scheduler
// in channel: one track request per item (in_valid / in_stall); the item with
//   last_request set closes the batch. the block stalls its input from the
//   closing item until the last result of that batch sits in the output register.
// out channel: one result item per stored request (out_valid / out_stall), in
//   scan order: ascending from start_track upward, then descending below it.
//   total_movement is nonzero only on the item with last_result set.
// config: cfg_wr_en / cfg_index / cfg_wdata, written while the block is idle.
// operation: requests load one per cycle, each inserted in order into a chain of
//   MAX_REQUESTS sorting cells. after the closing item, a split pass moves the
//   requests below start_track onto a per-cell stack, then results leave one per
//   cycle while the output is not stalled, with a pause when the sweep turns.
// requests beyond MAX_REQUESTS are dropped and flagged through overflow.
// reset (rst, synchronous) empties the chain and the output register and
//   restores start_track to 0 and last_track to 199.
// a stall on the output holds the result in place; the chain waits with it.
module scan_disk_scheduler #(
  parameter int MAX_REQUESTS = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  sdsch_pkg::request_t        in_item,
  output logic                       out_valid,
  input  logic                       out_stall,
  output sdsch_pkg::result_t         out_item,
  input  logic                       cfg_wr_en,
  input  logic                       cfg_index,
  input  logic [sdsch_pkg::TRACK_W-1:0] cfg_wdata
);
  import sdsch_pkg::*;

  localparam int CNT_W = $clog2(MAX_REQUESTS + 1);

  typedef enum logic [3:0] {
    ST_LOAD  = 4'b0001,
    ST_SPLIT = 4'b0010,
    ST_UP    = 4'b0100,
    ST_DOWN  = 4'b1000
  } state_t;

  state_t             state, state_next;
  logic [TRACK_W-1:0] start_track, last_track;
  logic [CNT_W-1:0]   count;
  logic               ovf;
  logic [TRACK_W-1:0] min_track, max_track;
  logic [MOVE_W-1:0]  movement;

  cell_cmd_t          cmd;
  cell_link_t         links  [MAX_REQUESTS];
  cell_link_t         lefts  [MAX_REQUESTS];
  cell_link_t         rights [MAX_REQUESTS];

  logic               in_acc, full, take, out_free;
  logic               emit, batch_done;
  result_t            emit_item;
  logic [TRACK_W-1:0] turn;
  logic [MOVE_W-1:0]  movement_next;

  // ---------------- configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      start_track <= START_TRACK_RESET;
      last_track  <= LAST_TRACK_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_START_TRACK: start_track <= cfg_wdata;
        CFG_LAST_TRACK:  last_track  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---------------- cell chain
  // cell 0 is the lowest track; the stack grows from cell 0 upward
  genvar gi;
  generate
    for (gi = 0; gi < MAX_REQUESTS; gi++) begin : g_cell
      if (gi == 0) begin : g_head
        // left edge: nothing below, pushes come from the sorted head
        assign lefts[gi] = '{sort_valid: 1'b0, sort_val: '0, stack_valid: 1'b1,
                             stack_val: links[0].sort_val, gt: 1'b0};
      end else begin : g_mid
        assign lefts[gi] = links[gi-1];
      end
      if (gi == MAX_REQUESTS - 1) begin : g_tail
        assign rights[gi] = '0;
      end else begin : g_body
        assign rights[gi] = links[gi+1];
      end
      sdsch_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .cmd   (cmd),
        .left  (lefts[gi]),
        .right (rights[gi]),
        .link  (links[gi])
      );
    end
  endgenerate

  // ---------------- handshake helpers
  assign in_stall = (state != ST_LOAD);
  assign in_acc   = in_valid && !in_stall;
  assign full     = (count == CNT_W'(MAX_REQUESTS));
  assign take     = in_acc && !full;
  assign out_free = !out_valid || !out_stall;

  // turning track is the largest of last_track, start and highest request
  always_comb begin
    turn = last_track;
    if (start_track > turn) begin
      turn = start_track;
    end
    if (max_track > turn) begin
      turn = max_track;
    end
    if (min_track < start_track) begin
      movement_next = {1'b0, turn - start_track} + {1'b0, turn - min_track};
    end else begin
      movement_next = {1'b0, max_track - start_track};
    end
  end

  // ---------------- sequencer
  always_comb begin
    state_next   = state;
    cmd.sort_op  = SORT_HOLD;
    cmd.stack_op = STK_HOLD;
    cmd.key      = in_item.request_track;
    emit         = 1'b0;
    batch_done   = 1'b0;
    emit_item    = '{served_track: links[0].sort_val, total_movement: '0,
                     overflow: ovf, last_result: 1'b0};
    unique case (state)
      ST_LOAD: begin
        if (take) begin
          cmd.sort_op = SORT_INSERT;
        end
        if (in_acc && in_item.last_request) begin
          state_next = ST_SPLIT;
        end
      end
      ST_SPLIT: begin
        // requests below start go onto the stack, to be served on the way back
        if (links[0].sort_valid && (links[0].sort_val < start_track)) begin
          cmd.sort_op  = SORT_POP;
          cmd.stack_op = STK_PUSH;
        end else begin
          state_next = ST_UP;
        end
      end
      ST_UP: begin
        if (out_free) begin
          if (links[0].sort_valid) begin
            emit        = 1'b1;
            cmd.sort_op = SORT_POP;
            emit_item.last_result = !links[1].sort_valid && !links[0].stack_valid;
            if (emit_item.last_result) begin
              batch_done = 1'b1;
              state_next = ST_LOAD;
            end
          end else begin
            state_next = ST_DOWN;
          end
        end
      end
      ST_DOWN: begin
        if (out_free) begin
          emit                   = 1'b1;
          cmd.stack_op           = STK_POP;
          emit_item.served_track = links[0].stack_val;
          emit_item.last_result  = !links[1].stack_valid;
          if (emit_item.last_result) begin
            batch_done = 1'b1;
            state_next = ST_LOAD;
          end
        end
      end
      default: state_next = ST_LOAD;
    endcase
    if (emit_item.last_result) begin
      emit_item.total_movement = movement;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // ---------------- batch bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ovf   <= 1'b0;
    end else if (batch_done) begin
      count <= '0;
      ovf   <= 1'b0;
    end else if (in_acc) begin
      if (full) begin
        ovf <= 1'b1;
      end else begin
        count <= count + 1'b1;
      end
    end
  end

  // lowest and highest stored request, for the movement total
  always_ff @(posedge clk) begin
    if (take) begin
      if ((count == '0) || (in_item.request_track < min_track)) begin
        min_track <= in_item.request_track;
      end
      if ((count == '0) || (in_item.request_track > max_track)) begin
        max_track <= in_item.request_track;
      end
    end
    if (state == ST_SPLIT) begin
      movement <= movement_next;
    end
  end

  // ---------------- output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_item <= emit_item;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_REQUESTS))
    else $error("request count beyond capacity");

  a_sort_packed: assert property (@(posedge clk) disable iff (rst)
    links[1].sort_valid |-> links[0].sort_valid)
    else $error("sorted chain has a hole at its head");

  a_down_has_stack: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DOWN) |-> links[0].stack_valid)
    else $error("descending pass with empty stack");

  a_stack_below: assert property (@(posedge clk) disable iff (rst)
    links[0].stack_valid |-> (links[0].stack_val < start_track))
    else $error("stacked request not below start");

  a_up_at_or_above: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_UP) && links[0].sort_valid) |-> (links[0].sort_val >= start_track))
    else $error("ascending pass serves a request below start");

  a_done_empties: assert property (@(posedge clk) disable iff (rst)
    batch_done |=> (!links[0].sort_valid && !links[0].stack_valid))
    else $error("chain not empty after final result");
`endif

endmodule

/* verif/scan_order_checker.sv */
module scan_order_checker #(
  parameter int MAX_REQUESTS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  sdsch_pkg::request_t           in_item,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  sdsch_pkg::result_t            out_item,
  input  logic                          cfg_wr_en,
  input  logic                          cfg_index,
  input  logic [sdsch_pkg::TRACK_W-1:0] cfg_wdata,
  output int                            failures,
  output int                            outstanding,
  output int                            results_seen
);
  import sdsch_pkg::*;

  logic [TRACK_W-1:0] head_start;
  logic [TRACK_W-1:0] turn_floor;
  logic [TRACK_W-1:0] held [MAX_REQUESTS];
  int                 held_n;
  logic               dropped;
  result_t            due_results[$];

  // sort the held batch and queue its results in sweep order
  task automatic schedule_batch();
    logic [TRACK_W-1:0] order [MAX_REQUESTS];
    logic [TRACK_W-1:0] visit [MAX_REQUESTS];
    logic [TRACK_W-1:0] key;
    int      n, up, i, j, turn, travel;
    result_t r;
    n = held_n;
    for (i = 0; i < n; i++) order[i] = held[i];
    for (i = 1; i < n; i++) begin
      key = order[i];
      j = i;
      while (j > 0 && order[j-1] > key) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = key;
    end
    up = 0;
    while (up < n && order[up] < head_start) up++;
    travel = 0;
    if (up > 0) begin
      turn = int'(turn_floor);
      if (int'(head_start) > turn) turn = int'(head_start);
      if (int'(order[n-1]) > turn) turn = int'(order[n-1]);
      travel = (turn - int'(head_start)) + (turn - int'(order[0]));
    end else if (n > 0) begin
      travel = int'(order[n-1]) - int'(head_start);
    end
    // upward pass, then the reverse pass below the start
    j = 0;
    for (i = up; i < n; i++) visit[j++] = order[i];
    for (i = up - 1; i >= 0; i--) visit[j++] = order[i];
    for (i = 0; i < n; i++) begin
      r.served_track   = visit[i];
      r.overflow       = dropped;
      r.last_result    = (i == n - 1);
      r.total_movement = (i == n - 1) ? travel[MOVE_W-1:0] : '0;
      due_results.push_back(r);
    end
    held_n = 0;
    dropped = 1'b0;
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      failures++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      head_start = START_TRACK_RESET;
      turn_floor = LAST_TRACK_RESET;
      held_n = 0;
      dropped = 1'b0;
      failures = 0;
      results_seen = 0;
      due_results.delete();
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == CFG_START_TRACK) head_start = cfg_wdata;
        else turn_floor = cfg_wdata;
      end
      if (out_valid && !out_stall) begin
        results_seen++;
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result item, served_track %0d", $time,
                   out_item.served_track);
          failures++;
        end else begin
          want = due_results.pop_front();
          check_field("served_track", want.served_track, out_item.served_track);
          check_field("total_movement", want.total_movement, out_item.total_movement);
          check_field("overflow", want.overflow, out_item.overflow);
          check_field("last_result", want.last_result, out_item.last_result);
        end
      end
      if (in_valid && !in_stall) begin
        if (held_n < MAX_REQUESTS) held[held_n++] = in_item.request_track;
        else dropped = 1'b1;
        if (in_item.last_request) schedule_batch();
      end
    end
    outstanding <= due_results.size();
  end

endmodule

/* verif/testbench.sv */
module testbench;
  import sdsch_pkg::*;

  localparam int CAPACITY = 32;

  logic               clk = 1'b0;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  request_t           in_item;
  logic               out_valid;
  logic               out_stall = 1'b0;
  result_t            out_item;
  logic               cfg_wr_en;
  logic               cfg_index;
  logic [TRACK_W-1:0] cfg_wdata;

  int failures, outstanding, results_seen;

  // idle mix, percent of cycles
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // long output hold: toggling hold_req asks the stall process for one
  bit hold_req = 1'b0;
  bit hold_ack = 1'b0;
  int hold_left = 0;

  // current register values, used to aim requests at the interesting tracks
  logic [TRACK_W-1:0] cur_start;
  logic [TRACK_W-1:0] cur_last;

  int requests_sent = 0;
  int batches_sent = 0;
  int overflow_batches = 0;
  int batch_len = 0;

  always #6 clk = ~clk;

  scan_disk_scheduler #(
    .MAX_REQUESTS(CAPACITY)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  scan_order_checker #(
    .MAX_REQUESTS(CAPACITY)
  ) u_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_item      (in_item),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_item     (out_item),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .failures     (failures),
    .outstanding  (outstanding),
    .results_seen (results_seen)
  );

  // receiver side: random stalls, or a long hold once asked for
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      // hold long enough for the chain to fill and the input to back up
      out_stall <= 1'b1;
      hold_left <= 300;
      hold_ack <= hold_req;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // offer one request item, with random idle cycles ahead of it; valid stays
  // high after acceptance so back-to-back items need no extra edge
  task automatic send_request(input logic [TRACK_W-1:0] track, input logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= '{request_track: track, last_request: last};
    do @(posedge clk); while (in_stall);
    requests_sent++;
    batch_len++;
    if (last) begin
      batches_sent++;
      if (batch_len > CAPACITY) overflow_batches++;
      batch_len = 0;
    end
  endtask

  // drop valid and wait until every predicted result has come out
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // registers change only while the block is idle, after the output stage has
  // settled from the last result
  task automatic retune(input logic [TRACK_W-1:0] s, input logic [TRACK_W-1:0] l);
    wait_idle();
    repeat (8) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_START_TRACK;
    cfg_wdata <= s;
    @(posedge clk);
    cfg_index <= CFG_LAST_TRACK;
    cfg_wdata <= l;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_start = s;
    cur_last = l;
  endtask

  // run limit, far beyond the slowest legal run
  initial begin
    #(12 * 400000);
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    int                 mode, phase_items, size, nbatch, b, i;
    bit                 first;
    logic [TRACK_W-1:0] s, l, t;

    rst <= 1'b1;
    in_valid <= 1'b0;
    in_item <= '0;
    cfg_wr_en <= 1'b0;
    cfg_index <= CFG_START_TRACK;
    cfg_wdata <= '0;
    cur_start = START_TRACK_RESET;
    cur_last = LAST_TRACK_RESET;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // reset registers: start at 0, so nothing lies below and the head
    // stops at the highest request; a request on the start track itself
    send_request(8'd5, 1'b0);
    send_request(8'd0, 1'b0);
    send_request(8'd199, 1'b1);

    // textbook batch: upward pass, run to the turning track, come back down
    retune(8'd53, 8'd199);
    send_request(8'd98, 1'b0);
    send_request(8'd183, 1'b0);
    send_request(8'd37, 1'b0);
    send_request(8'd122, 1'b0);
    send_request(8'd14, 1'b0);
    send_request(8'd124, 1'b0);
    send_request(8'd65, 1'b0);
    send_request(8'd67, 1'b1);

    // single request on the start track, zero movement
    send_request(8'd53, 1'b1);

    // turning track at 0: start and the top request extend the sweep
    retune(8'd128, 8'd0);
    send_request(8'd0, 1'b0);
    send_request(8'd255, 1'b0);
    send_request(8'd200, 1'b1);

    // start at the top track, turning track at 1
    retune(8'd255, 8'd1);
    send_request(8'd10, 1'b0);
    send_request(8'd255, 1'b1);

    // start at 0 with the widest turning track
    retune(8'd0, 8'd255);
    send_request(8'd255, 1'b0);
    send_request(8'd0, 1'b1);

    // everything below a start that sits above the turning track
    retune(8'd200, 8'd150);
    send_request(8'd180, 1'b0);
    send_request(8'd190, 1'b1);

    // random batches under three idle mixes
    for (mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          send_idle_pct = 25;
          recv_idle_pct = 47;
        end
        1: begin
          send_idle_pct = 47;
          recv_idle_pct = 25;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      phase_items = 0;
      first = 1'b1;
      while (phase_items < 35) begin
        if (first || $urandom_range(0, 2) == 0) begin
          case ($urandom_range(0, 3))
            0: s = 8'd0;
            1: s = 8'd255;
            default: s = $urandom_range(0, 255);
          endcase
          case ($urandom_range(0, 4))
            0: l = 8'd0;
            1: l = 8'd1;
            2: l = 8'd255;
            3: l = LAST_TRACK_RESET;
            default: l = $urandom_range(0, 255);
          endcase
          retune(s, l);
        end
        nbatch = 1;
        if (first && mode == 0) begin
          // more requests than the store holds, the closing one dropped too
          size = $urandom_range(CAPACITY + 1, CAPACITY + 4);
        end else if (first && mode == 1) begin
          // store exactly full
          size = CAPACITY;
        end else if (first && mode == 2) begin
          // output held off while two batches are offered back to back
          hold_req <= ~hold_req;
          size = 12;
          nbatch = 2;
        end else if ($urandom_range(0, 7) == 0) begin
          size = $urandom_range(20, CAPACITY - 1);
        end else begin
          size = $urandom_range(1, 8);
        end
        for (b = 0; b < nbatch; b++) begin
          for (i = 0; i < size; i++) begin
            // lean toward the edges and the register values
            case ($urandom_range(0, 9))
              0: t = 8'd0;
              1: t = 8'd255;
              2: t = cur_start;
              3: t = cur_last;
              default: t = $urandom_range(0, 255);
            endcase
            send_request(t, i == size - 1);
          end
          phase_items += size;
        end
        first = 1'b0;
      end
    end

    wait_idle();
    repeat (20) @(posedge clk);
    $display("covered %0d batches, %0d requests, %0d batches over capacity",
             batches_sent, requests_sent, overflow_batches);
    $display("%0d results checked over three idle mixes and one long output hold",
             results_seen);
    if (failures == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* scan_disk_scheduler.f */
hw/rtl/sdsch_pkg.sv
hw/rtl/sdsch_cell.sv
hw/rtl/scan_disk_scheduler.sv
verif/scan_order_checker.sv
verif/testbench.sv
